>>> hw/rtl/lfupr_pkg.sv
// ---------------------------------------------------------------------------
// LFU page replacement package
// Shared constants, field widths, token control struct and state encoding.
// ---------------------------------------------------------------------------
package lfupr_pkg;

  // Default configuration.
  localparam int NUM_FRAMES_D = 4;
  localparam int PAGE_BITS_D  = 16;
  localparam int COUNT_BITS_D = 16;

  // Fixed field widths of the stream payloads.
  localparam int PAGE_FW  = 16;
  localparam int RAND_W   = 8;
  localparam int FRAME_FW = 2;
  localparam int CNT_FW   = 16;

  localparam int IN_W      = 24;
  localparam int OUT_USED  = 1 + FRAME_FW + 1 + PAGE_FW + CNT_FW;
  localparam int OUT_W     = 40;
  localparam int OUT_PAD   = OUT_W - OUT_USED;

  // Control part of the token that walks down the row of frame cells.
  typedef struct packed {
    logic vld;       // token present
    logic fill;      // 0: lookup pass, 1: replacement pass
    logic hit;       // lookup pass found the page
    logic done;      // replacement pass already placed the page
    logic ev_valid;  // a resident page was displaced
  } tok_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FILL,
    ST_OUT
  } state_t;

endpackage

>>> hw/rtl/lfupr_cell.sv
// ---------------------------------------------------------------------------
// LFU frame cell
// Holds one frame (valid, page, use count) and registers the token that
// passes through it, updating the lookup or replacement fields on the way.
// ---------------------------------------------------------------------------
module lfupr_cell
  import lfupr_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int NUM_FRAMES = NUM_FRAMES_D,
  parameter int PAGE_BITS  = PAGE_BITS_D,
  parameter int COUNT_BITS = COUNT_BITS_D,
  localparam int NW = $clog2(NUM_FRAMES + 1),
  localparam int IW = $clog2(NUM_FRAMES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tok_ctrl_t             i_ctrl,
  input  logic [PAGE_BITS-1:0]  i_page,
  input  logic [COUNT_BITS-1:0] i_least,
  input  logic [NW-1:0]         i_n,
  input  logic [IW-1:0]         i_idx,
  input  logic [PAGE_BITS-1:0]  i_ev_page,
  input  logic [COUNT_BITS-1:0] i_ev_cnt,
  output tok_ctrl_t             o_ctrl,
  output logic [PAGE_BITS-1:0]  o_page,
  output logic [COUNT_BITS-1:0] o_least,
  output logic [NW-1:0]         o_n,
  output logic [IW-1:0]         o_idx,
  output logic [PAGE_BITS-1:0]  o_ev_page,
  output logic [COUNT_BITS-1:0] o_ev_cnt
);

  logic                  valid_r, valid_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;

  tok_ctrl_t             ctrl_r, ctrl_nxt;
  logic [PAGE_BITS-1:0]  tpage_r, tpage_nxt;
  logic [COUNT_BITS-1:0] least_r, least_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [PAGE_BITS-1:0]  evp_r, evp_nxt;
  logic [COUNT_BITS-1:0] evc_r, evc_nxt;

  logic lesser, same;

  always_comb begin
    lesser    = count_r < i_least;
    same      = count_r == i_least;
    valid_nxt = valid_r;
    page_nxt  = page_r;
    count_nxt = count_r;
    ctrl_nxt  = i_ctrl;
    tpage_nxt = i_page;
    least_nxt = i_least;
    n_nxt     = i_n;
    idx_nxt   = i_idx;
    evp_nxt   = i_ev_page;
    evc_nxt   = i_ev_cnt;
    if (i_ctrl.vld) begin
      if (!i_ctrl.fill) begin
        if (valid_r && (page_r == i_page) && !i_ctrl.hit) begin
          ctrl_nxt.hit = 1'b1;
          idx_nxt      = IW'(IDX);
          if (count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end
        end
        // Running minimum and number of frames that share it.
        if (lesser) begin
          least_nxt = count_r;
          n_nxt     = NW'(1);
        end else if (same) begin
          n_nxt = i_n + 1'b1;
        end
      end else if (!i_ctrl.done && same) begin
        if (i_n == '0) begin
          valid_nxt         = 1'b1;
          page_nxt          = i_page;
          count_nxt         = COUNT_BITS'(1);
          ctrl_nxt.done     = 1'b1;
          ctrl_nxt.ev_valid = valid_r;
          idx_nxt           = IW'(IDX);
          evp_nxt           = valid_r ? page_r : '0;
          evc_nxt           = valid_r ? count_r : '0;
        end else begin
          n_nxt = i_n - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      count_r <= '0;
      ctrl_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    tpage_r <= tpage_nxt;
    least_r <= least_nxt;
    n_r     <= n_nxt;
    idx_r   <= idx_nxt;
    evp_r   <= evp_nxt;
    evc_r   <= evc_nxt;
  end

  assign o_ctrl    = ctrl_r;
  assign o_page    = tpage_r;
  assign o_least   = least_r;
  assign o_n       = n_r;
  assign o_idx     = idx_r;
  assign o_ev_page = evp_r;
  assign o_ev_cnt  = evc_r;

endmodule

>>> hw/rtl/lfupr_mod.sv
// ---------------------------------------------------------------------------
// Tie-break modulo unit
// Restoring division of the random draw by the candidate count, one
// quotient bit per cycle; only the remainder is kept.
// ---------------------------------------------------------------------------
module lfupr_mod
  import lfupr_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_D,
  localparam int NW = $clog2(NUM_FRAMES + 1),
  localparam int CW = $clog2(RAND_W + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [NW-1:0]     divisor,
  output logic              done,
  output logic [NW-1:0]     rem
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [RAND_W-1:0] quo_r, quo_nxt;
  logic [NW-1:0]     rem_r, rem_nxt;
  logic [NW-1:0]     div_r, div_nxt;
  logic [NW:0]       trial;
  logic [NW:0]       diff;

  always_comb begin
    trial    = {rem_r, quo_r[RAND_W-1]};
    diff     = trial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(RAND_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it fits NW bits.
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[NW-1:0] : trial[NW-1:0];
      quo_nxt = {quo_r[RAND_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> hw/rtl/lfu_page_replacement_random_tie_unit.sv
// ---------------------------------------------------------------------------
// LFU page replacement with random tie-break
// A request walks a row of frame cells, one cell per cycle. A hit is reported
// from the first walk; a miss adds a modulo step that draws among the tied
// least-used frames and a second walk to place the page. A new request is
// taken only after the result of the last one has been loaded for output.
// Synchronous reset empties all frames and clears the control state.
// ---------------------------------------------------------------------------
module lfu_page_replacement_random_tie_unit
  import lfupr_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_D,
  parameter int PAGE_BITS  = PAGE_BITS_D,
  parameter int COUNT_BITS = COUNT_BITS_D
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // [15:0] page, [23:16] random_value
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // [0] hit, [2:1] frame, [3] evicted_valid, [19:4] evicted_page,
  // [35:20] evicted_count, [39:36] zero
  output logic [OUT_W-1:0] out_tdata
);

  localparam int NW = $clog2(NUM_FRAMES + 1);
  localparam int IW = $clog2(NUM_FRAMES);

  tok_ctrl_t             ch_ctrl  [NUM_FRAMES+1];
  logic [PAGE_BITS-1:0]  ch_page  [NUM_FRAMES+1];
  logic [COUNT_BITS-1:0] ch_least [NUM_FRAMES+1];
  logic [NW-1:0]         ch_n     [NUM_FRAMES+1];
  logic [IW-1:0]         ch_idx   [NUM_FRAMES+1];
  logic [PAGE_BITS-1:0]  ch_evp   [NUM_FRAMES+1];
  logic [COUNT_BITS-1:0] ch_evc   [NUM_FRAMES+1];

  state_t                state_r, state_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [RAND_W-1:0]     rnd_r, rnd_nxt;
  logic [COUNT_BITS-1:0] least_r, least_nxt;

  logic                  res_hit_r, res_evv_r;
  logic [IW-1:0]         res_idx_r;
  logic [PAGE_BITS-1:0]  res_evp_r;
  logic [COUNT_BITS-1:0] res_evc_r;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_W-1:0]      out_tdata_r;

  logic                  accept, inj_scan, inj_fill, div_start, res_en, out_load;
  logic                  div_done;
  logic [NW-1:0]         div_rem;
  tok_ctrl_t             tail;

  assign tail   = ch_ctrl[NUM_FRAMES];
  assign accept = in_tvalid && in_tready;

  // Token entering the first cell.
  always_comb begin
    ch_ctrl[0]  = '0;
    ch_page[0]  = page_r;
    ch_least[0] = '1;
    ch_n[0]     = '0;
    ch_idx[0]   = '0;
    ch_evp[0]   = '0;
    ch_evc[0]   = '0;
    if (inj_scan) begin
      ch_ctrl[0].vld = 1'b1;
      ch_page[0]     = PAGE_BITS'(in_tdata[PAGE_FW-1:0]);
    end else if (inj_fill) begin
      ch_ctrl[0].vld  = 1'b1;
      ch_ctrl[0].fill = 1'b1;
      ch_least[0]     = least_r;
      ch_n[0]         = div_rem;
    end
  end

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    lfupr_cell #(
      .IDX        (g),
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .i_ctrl    (ch_ctrl[g]),
      .i_page    (ch_page[g]),
      .i_least   (ch_least[g]),
      .i_n       (ch_n[g]),
      .i_idx     (ch_idx[g]),
      .i_ev_page (ch_evp[g]),
      .i_ev_cnt  (ch_evc[g]),
      .o_ctrl    (ch_ctrl[g+1]),
      .o_page    (ch_page[g+1]),
      .o_least   (ch_least[g+1]),
      .o_n       (ch_n[g+1]),
      .o_idx     (ch_idx[g+1]),
      .o_ev_page (ch_evp[g+1]),
      .o_ev_cnt  (ch_evc[g+1])
    );
  end

  lfupr_mod #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rnd_r),
    .divisor  (ch_n[NUM_FRAMES]),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (tail.vld) state_nxt = tail.hit ? ST_OUT : ST_DIV;
      end
      ST_DIV:  if (div_done) state_nxt = ST_FILL;
      ST_FILL: if (tail.vld) state_nxt = ST_OUT;
      ST_OUT:  if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    inj_scan  = (state_r == ST_IDLE) && in_tvalid;
    inj_fill  = (state_r == ST_DIV) && div_done;
    div_start = (state_r == ST_SCAN) && tail.vld && !tail.hit;
    res_en    = ((state_r == ST_SCAN) && tail.vld && tail.hit) ||
                ((state_r == ST_FILL) && tail.vld);
    out_load  = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);
  end

  always_comb begin
    page_nxt  = page_r;
    rnd_nxt   = rnd_r;
    least_nxt = least_r;
    if (accept) begin
      page_nxt = PAGE_BITS'(in_tdata[PAGE_FW-1:0]);
      rnd_nxt  = in_tdata[PAGE_FW +: RAND_W];
    end
    if (div_start) begin
      least_nxt = ch_least[NUM_FRAMES];
    end
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    rnd_r   <= rnd_nxt;
    least_r <= least_nxt;
    if (res_en) begin
      res_hit_r <= tail.hit;
      res_idx_r <= ch_idx[NUM_FRAMES];
      res_evv_r <= tail.ev_valid;
      res_evp_r <= ch_evp[NUM_FRAMES];
      res_evc_r <= ch_evc[NUM_FRAMES];
    end
    if (out_load) begin
      out_tdata_r <= {{OUT_PAD{1'b0}}, CNT_FW'(res_evc_r), PAGE_FW'(res_evp_r),
                      res_evv_r, FRAME_FW'(res_idx_r), res_hit_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

>>> hw/rtl/lfupr_chk.sv
// ---------------------------------------------------------------------------
// LFU page replacement port checker
// Watches the stream ports of the top level and flags illegal sequences.
// ---------------------------------------------------------------------------
module lfupr_chk
  import lfupr_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [IN_W-1:0]  in_tdata,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [PAGE_FW-1:0] in_page;
  assign in_page = in_tdata[PAGE_FW-1:0];

  // A result waiting on the consumer keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A hit never reports a displaced page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[OUT_W-1:3] == '0)
    else $error("hit result carries eviction data");

  // Without a displacement the eviction fields read zero.
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[OUT_W-1:4] == '0)
    else $error("eviction fields set without a displaced page");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_page == in_page) |=> !in_tready)
    else $error("second request taken while one is in progress");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind lfu_page_replacement_random_tie_unit lfupr_chk u_lfupr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/sv/lfupr_replacement_checker.sv
// ---------------------------------------------------------------------------
// LFU page replacement checker
// Watches both stream channels of the replacement unit. Every accepted
// request is run through a cycle-free model of the frame table, and each
// result that the unit returns is compared field by field against the oldest
// pending prediction.
// ---------------------------------------------------------------------------
module lfupr_replacement_checker
  import lfupr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  // [15:0] page, [23:16] random_value
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  // [0] hit, [2:1] frame, [3] evicted_valid, [19:4] evicted_page,
  // [35:20] evicted_count, [39:36] zero
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               outstanding,
  output int               results_seen,
  output int               hits_seen,
  output int               evictions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = NUM_FRAMES_D;
  localparam logic [COUNT_BITS_D-1:0] USE_COUNT_MAX = '1;

  typedef struct packed {
    logic                hit;
    logic [FRAME_FW-1:0] frame;
    logic                ev_valid;
    logic [PAGE_FW-1:0]  ev_page;
    logic [CNT_FW-1:0]   ev_count;
  } page_outcome_t;

  // Model copy of the frame table.
  logic                    resident_valid [NF];
  logic [PAGE_BITS_D-1:0]  resident_page  [NF];
  logic [COUNT_BITS_D-1:0] use_count      [NF];

  page_outcome_t outcome_fifo [$];

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  // Looks the page up, bumps or replaces a frame and returns what the unit
  // must report for this request.
  function automatic page_outcome_t lfu_lookup_replace(input logic [PAGE_FW-1:0] pg_in,
                                                       input logic [RAND_W-1:0] rv);
    logic [PAGE_BITS_D-1:0]  pg;
    logic [COUNT_BITS_D-1:0] least;
    int                      cand [NF];
    int                      ncand;
    int                      pick;
    page_outcome_t           r;
    pg = pg_in[PAGE_BITS_D-1:0];
    r  = '0;
    // The lowest matching frame wins; an empty frame never matches.
    for (int i = 0; i < NF; i++) begin
      if (resident_valid[i] && resident_page[i] == pg) begin
        if (use_count[i] != USE_COUNT_MAX) use_count[i] = use_count[i] + 1'b1;
        r.hit   = 1'b1;
        r.frame = FRAME_FW'(i);
        return r;
      end
    end
    least = use_count[0];
    ncand = 0;
    for (int i = 0; i < NF; i++) begin
      if (use_count[i] < least) begin
        least = use_count[i];
        ncand = 0;
      end
      if (use_count[i] == least) begin
        cand[ncand] = i;
        ncand++;
      end
    end
    pick    = cand[int'(rv) % ncand];
    r.frame = FRAME_FW'(pick);
    if (resident_valid[pick]) begin
      r.ev_valid = 1'b1;
      r.ev_page  = PAGE_FW'(resident_page[pick]);
      r.ev_count = CNT_FW'(use_count[pick]);
    end
    resident_valid[pick] = 1'b1;
    resident_page[pick]  = pg;
    use_count[pick]      = COUNT_BITS_D'(1);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    page_outcome_t want;
    page_outcome_t got;
    if (!rst_n) begin
      for (int i = 0; i < NF; i++) begin
        resident_valid[i] = 1'b0;
        resident_page[i]  = '0;
        use_count[i]      = '0;
      end
      outcome_fifo.delete();
      outstanding = 0;
    end else begin
      // Results always trail their request, so the result side is handled
      // before a request accepted at the same edge.
      if (out_tvalid && out_tready) begin
        got.hit      = out_tdata[0];
        got.frame    = out_tdata[2:1];
        got.ev_valid = out_tdata[3];
        got.ev_page  = out_tdata[19:4];
        got.ev_count = out_tdata[35:20];
        if (outcome_fifo.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request pending (data %h)",
                                    results_seen, out_tdata));
        end else begin
          want = outcome_fifo.pop_front();
          outstanding--;
          if (want.hit) hits_seen++;
          if (want.ev_valid) evictions_seen++;
          if (got.hit !== want.hit)
            report_mismatch($sformatf("result %0d hit: got %b want %b",
                                      results_seen, got.hit, want.hit));
          if (got.frame !== want.frame)
            report_mismatch($sformatf("result %0d frame: got %0d want %0d",
                                      results_seen, got.frame, want.frame));
          if (got.ev_valid !== want.ev_valid)
            report_mismatch($sformatf("result %0d evicted_valid: got %b want %b",
                                      results_seen, got.ev_valid, want.ev_valid));
          if (got.ev_page !== want.ev_page)
            report_mismatch($sformatf("result %0d evicted_page: got %h want %h",
                                      results_seen, got.ev_page, want.ev_page));
          if (got.ev_count !== want.ev_count)
            report_mismatch($sformatf("result %0d evicted_count: got %0d want %0d",
                                      results_seen, got.ev_count, want.ev_count));
          if (out_tdata[OUT_W-1:OUT_USED] !== '0)
            report_mismatch($sformatf("result %0d padding bits not zero: %b",
                                      results_seen, out_tdata[OUT_W-1:OUT_USED]));
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        outcome_fifo.push_back(lfu_lookup_replace(in_tdata[PAGE_FW-1:0],
                                                  in_tdata[IN_W-1:PAGE_FW]));
        outstanding++;
      end
    end
  end

endmodule

>>> tb/sv/lfu_page_replacement_random_tie_unit_tb.sv
// ---------------------------------------------------------------------------
// LFU page replacement unit testbench
// Drives page requests into the replacement unit under several mixes of
// sender gaps and receiver back-pressure: a directed opening followed by
// random traffic over small page pools with churn.
// The checker beside the unit predicts and compares every result.
// ---------------------------------------------------------------------------
module lfu_page_replacement_random_tie_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lfupr_pkg::*;

  localparam int PHASE_REQS    = 212;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  int fail_count;
  int outstanding;
  int results_seen;
  int hits_seen;
  int evictions_seen;

  lfu_page_replacement_random_tie_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  lfupr_replacement_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .results_seen   (results_seen),
    .hits_seen      (hits_seen),
    .evictions_seen (evictions_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Offers one request and returns at the falling edge after it is taken.
  // Valid is left high so that back-to-back requests keep it up.
  task automatic push_request(input logic [PAGE_FW-1:0] pg, input logic [RAND_W-1:0] rv);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_W'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rv, pg};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Most requests come from a small pool of pages so that hits, ties and
  // evictions all happen; the pool is redrawn now and then to force churn.
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n);
    logic [PAGE_FW-1:0] pool [8];
    int                 pool_n;
    int                 sel;
    logic [PAGE_FW-1:0] pg;
    logic [RAND_W-1:0]  rv;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    pool_n = 2;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        pool_n = $urandom_range(2, 7);
        for (int j = 0; j < 8; j++) pool[j] = PAGE_FW'($urandom);
      end
      sel = $urandom_range(0, 99);
      if (sel < 72) pg = pool[$urandom_range(0, pool_n - 1)];
      else if (sel < 78) pg = $urandom_range(0, 1) ? '1 : '0;
      else pg = PAGE_FW'($urandom);
      sel = $urandom_range(0, 19);
      if (sel == 0) rv = '0;
      else if (sel == 1) rv = '1;
      else rv = RAND_W'($urandom_range(0, 255));
      push_request(pg, rv);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Page zero while every frame is empty and holds zero must still miss.
    push_request(16'h0000, 8'h00);
    push_request(16'h0000, 8'hFF);
    push_request(16'hFFFF, 8'hFF);
    push_request(16'h8000, 8'h07);
    push_request(16'h0001, 8'hC8);
    push_request(16'hFFFF, 8'h00);
    push_request(16'hFFFF, 8'h01);
    // Table is full now; misses evict among the least-used frames.
    push_request(16'h5555, 8'h02);
    push_request(16'hAAAA, 8'hFF);
    push_request(16'h0000, 8'h80);
    push_request(16'h1234, 8'h00);
    push_request(16'h1234, 8'h55);
    push_request(16'h7FFF, 8'hFE);
    push_request(16'h8000, 8'h01);
    push_request(16'h00FF, 8'hAA);
    push_request(16'hFF00, 8'h33);
    push_request(16'h0001, 8'hFF);
    push_request(16'h0002, 8'h03);
    wait_until_drained();

    run_random_phase(0, 0, PHASE_REQS);
    wait_until_drained();
    run_random_phase(59, 0, PHASE_REQS);
    wait_until_drained();
    run_random_phase(0, 59, PHASE_REQS);
    wait_until_drained();
    run_random_phase(28, 28, PHASE_REQS);
    wait_until_drained();

    repeat (40) @(posedge clk);
    $display("Run covered %0d requests: %0d hits, %0d misses, %0d evictions.",
             results_seen, hits_seen, results_seen - hits_seen, evictions_seen);
    $display("Traffic mixes: no gaps, sender gaps, receiver stalls, and both together.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
